// ----- hw/rtl/convex_polygon_sat_collision_core_defines.svh -----
// Shared assertion macros for the collision core.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef CONVEX_POLYGON_SAT_COLLISION_CORE_DEFINES_SVH
`define CONVEX_POLYGON_SAT_COLLISION_CORE_DEFINES_SVH

// Same-cycle check: when cond holds, conseq must hold as well
`define CPSAT_CHECK(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// Next-cycle check: when cond holds, conseq must hold in the cycle after
`define CPSAT_CHECK_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

// ----- hw/rtl/cpsat_pkg.sv -----
`timescale 1ns / 1ps

package cpsat_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int COORD_WIDTH  = 16;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int NUM_AXES     = 2 * MAX_VERTICES;
    localparam int EDGE_W       = COORD_WIDTH + 1;
    localparam int PROD_W       = EDGE_W + COORD_WIDTH;
    localparam int DOT_W        = PROD_W + 1;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
    localparam logic [1:0] STATUS_EMPTY    = 2'd2;

    localparam logic POLY_FIRST  = 1'b0;
    localparam logic POLY_SECOND = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_RUN
    } state_t;

    // Input word
    typedef struct packed {
        logic                          func;
        logic signed [COORD_WIDTH-1:0] vertex_x;
        logic signed [COORD_WIDTH-1:0] vertex_y;
        logic                          pair_done;
    } item_t;

    // Result word
    typedef struct packed {
        logic       intersect_res;
        logic [1:0] status;
    } result_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
    } vertex_t;

    // One projection axis (edge normal) waiting to enter the cell row
    typedef struct packed {
        logic                     valid;
        logic                     last;
        logic signed [EDGE_W-1:0] ax;
        logic signed [EDGE_W-1:0] ay;
    } axis_t;

    // Axis plus running projection intervals of both polygons
    typedef struct packed {
        logic                     valid;
        logic                     last;
        logic signed [EDGE_W-1:0] ax;
        logic signed [EDGE_W-1:0] ay;
        logic                     have1;
        logic signed [DOT_W-1:0]  min1;
        logic signed [DOT_W-1:0]  max1;
        logic                     have2;
        logic signed [DOT_W-1:0]  min2;
        logic signed [DOT_W-1:0]  max2;
    } token_t;

    // Edge from cur to nxt, turned into its normal (-ey, ex)
    function automatic axis_t make_axis(vertex_t cur, vertex_t nxt, logic act);
        logic signed [EDGE_W-1:0] ex;
        logic signed [EDGE_W-1:0] ey;
        axis_t                    a;
        ex      = EDGE_W'(nxt.x) - EDGE_W'(cur.x);
        ey      = EDGE_W'(nxt.y) - EDGE_W'(cur.y);
        a.valid = act;
        a.last  = 1'b0;
        a.ax    = -ey;
        a.ay    = ex;
        return a;
    endfunction

endpackage

// ----- hw/rtl/convex_polygon_sat_collision_core.sv -----
// Vertex words without pair_done are taken one per cycle, back to back, while busy is low.
// A pair_done word with an error reports in the cycle after it is accepted.
// A full test reports once every axis has been judged after the pair_done word:
// the axis chain feeds 2*MAX_VERTICES axes, one per cycle, through a row of
// MAX_VERTICES two-stage projection cells; busy holds until the last axis exits.
// Reset clears counts, overflow flag, state and the axis and token registers; vertices stay.
`timescale 1ns / 1ps
`include "convex_polygon_sat_collision_core_defines.svh"

module convex_polygon_sat_collision_core
    import cpsat_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  item_t   item,
    output logic    done,
    output result_t result
);

    state_t state_reg, state_next;

    logic [CNT_W-1:0] first_cnt_reg, first_cnt_next;
    logic [CNT_W-1:0] second_cnt_reg, second_cnt_next;
    logic             ovf_reg, ovf_next;

    logic       accept;
    logic       is_second;
    logic       room;
    logic       test_go;
    logic       err_valid;
    logic [1:0] err_status;
    logic       chain_load;
    logic       chain_shift;

    vertex_t wdata;
    vertex_t own_first   [MAX_VERTICES];
    vertex_t own_second  [MAX_VERTICES];
    axis_t   axis_first  [MAX_VERTICES];
    axis_t   axis_second [MAX_VERTICES];
    logic    wr_first    [MAX_VERTICES];
    logic    wr_second   [MAX_VERTICES];

    axis_t [NUM_AXES-1:0] axes_all;
    axis_t                head;
    token_t               feed;
    token_t               tok_chain [MAX_VERTICES+1];
    token_t               tail;

    assign accept    = start && !busy;
    assign is_second = item.func == POLY_SECOND;
    assign room      = is_second ? (second_cnt_reg < CNT_W'(MAX_VERTICES))
                                 : (first_cnt_reg < CNT_W'(MAX_VERTICES));
    assign wdata.x   = item.vertex_x;
    assign wdata.y   = item.vertex_y;
    assign tail      = tok_chain[MAX_VERTICES];

    // Count stored vertices, flag drops, decide the pair_done word, and clear after a test
    always_comb
    begin
        first_cnt_next  = first_cnt_reg;
        second_cnt_next = second_cnt_reg;
        ovf_next        = ovf_reg;
        test_go         = 1'b0;
        err_valid       = 1'b0;
        err_status      = STATUS_OK;
        if (state_reg == S_RUN && tail.last)
        begin
            first_cnt_next  = '0;
            second_cnt_next = '0;
            ovf_next        = 1'b0;
        end
        else if (accept)
        begin
            if (room)
            begin
                if (is_second)
                begin
                    second_cnt_next = second_cnt_reg + CNT_W'(1);
                end
                else
                begin
                    first_cnt_next = first_cnt_reg + CNT_W'(1);
                end
            end
            else
            begin
                ovf_next = 1'b1;
            end
            if (item.pair_done)
            begin
                if (ovf_reg || !room)
                begin
                    err_valid  = 1'b1;
                    err_status = STATUS_OVERFLOW;
                end
                else if (first_cnt_next == '0 || second_cnt_next == '0)
                begin
                    err_valid  = 1'b1;
                    err_status = STATUS_EMPTY;
                end
                else
                begin
                    test_go = 1'b1;
                end
                if (err_valid)
                begin
                    first_cnt_next  = '0;
                    second_cnt_next = '0;
                    ovf_next        = 1'b0;
                end
            end
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (test_go)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                state_next = S_RUN;
            end
            S_RUN:
            begin
                if (tail.last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        busy        = 1'b1;
        chain_load  = 1'b0;
        chain_shift = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
            end
            S_LOAD:
            begin
                chain_load = 1'b1;
            end
            S_RUN:
            begin
                chain_shift = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            first_cnt_reg  <= '0;
            second_cnt_reg <= '0;
            ovf_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            first_cnt_reg  <= first_cnt_next;
            second_cnt_reg <= second_cnt_next;
            ovf_reg        <= ovf_next;
        end
    end

    // Feed the head axis into the cell row while testing
    always_comb
    begin
        feed       = '0;
        feed.valid = chain_shift && head.valid;
        feed.last  = chain_shift && head.last;
        feed.ax    = head.ax;
        feed.ay    = head.ay;
    end

    assign tok_chain[0] = feed;

    // Row of projection cells, one vertex slot of each polygon per cell
    for (genvar k = 0; k < MAX_VERTICES; k++)
    begin : g_cell
        localparam int NXT = (k + 1) % MAX_VERTICES;

        assign wr_first[k]  = accept && !is_second && first_cnt_reg == CNT_W'(k);
        assign wr_second[k] = accept && is_second && second_cnt_reg == CNT_W'(k);
        assign axes_all[k]                = axis_first[k];
        assign axes_all[MAX_VERTICES + k] = axis_second[k];

        cpsat_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .idx         (IDX_W'(k)),
            .wr_first    (wr_first[k]),
            .wr_second   (wr_second[k]),
            .wdata       (wdata),
            .n_first     (first_cnt_reg),
            .n_second    (second_cnt_reg),
            .next_first  (own_first[NXT]),
            .next_second (own_second[NXT]),
            .head_first  (own_first[0]),
            .head_second (own_second[0]),
            .own_first   (own_first[k]),
            .own_second  (own_second[k]),
            .axis_first  (axis_first[k]),
            .axis_second (axis_second[k]),
            .tok_in      (tok_chain[k]),
            .tok_out     (tok_chain[k+1])
        );
    end

    cpsat_axis_chain u_axis_chain (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (chain_load),
        .shift   (chain_shift),
        .axes_in (axes_all),
        .head    (head)
    );

    cpsat_judge u_judge (
        .clk        (clk),
        .rst_n      (rst_n),
        .tok        (tail),
        .err_valid  (err_valid),
        .err_status (err_status),
        .done       (done),
        .result     (result)
    );

    `CPSAT_CHECK(a_clear_after_word, done && result.status == STATUS_OK, first_cnt_reg == '0 && second_cnt_reg == '0 && !ovf_reg, "store not cleared")
    `CPSAT_CHECK_NEXT(a_load_to_run, state_reg == S_LOAD, state_reg == S_RUN, "load not followed by run")
    `CPSAT_CHECK_NEXT(a_tail_reports, state_reg == S_RUN && tail.last, done && state_reg == S_IDLE, "closing axis lost")

endmodule

// ----- hw/rtl/cpsat_cell.sv -----
`timescale 1ns / 1ps

module cpsat_cell
    import cpsat_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] idx,
    input  logic             wr_first,
    input  logic             wr_second,
    input  vertex_t          wdata,
    input  logic [CNT_W-1:0] n_first,
    input  logic [CNT_W-1:0] n_second,
    input  vertex_t          next_first,
    input  vertex_t          next_second,
    input  vertex_t          head_first,
    input  vertex_t          head_second,
    output vertex_t          own_first,
    output vertex_t          own_second,
    output axis_t            axis_first,
    output axis_t            axis_second,
    input  token_t           tok_in,
    output token_t           tok_out
);

    vertex_t v_first_reg;
    vertex_t v_second_reg;

    token_t tok_a_reg;
    token_t tok_b_reg;
    token_t tok_b_next;

    logic signed [PROD_W-1:0] prod_fx_reg, prod_fx_next;
    logic signed [PROD_W-1:0] prod_fy_reg, prod_fy_next;
    logic signed [PROD_W-1:0] prod_sx_reg, prod_sx_next;
    logic signed [PROD_W-1:0] prod_sy_reg, prod_sy_next;

    logic signed [DOT_W-1:0] dot_first;
    logic signed [DOT_W-1:0] dot_second;

    logic [CNT_W-1:0] idx_w;
    logic             act_first;
    logic             act_second;
    logic             wrap_first;
    logic             wrap_second;

    assign idx_w       = CNT_W'(idx);
    assign act_first   = idx_w < n_first;
    assign act_second  = idx_w < n_second;
    assign wrap_first  = !((idx_w + CNT_W'(1)) < n_first);
    assign wrap_second = !((idx_w + CNT_W'(1)) < n_second);

    // Hold this cell's vertex of each polygon
    always_ff @(posedge clk)
    begin
        if (wr_first)
        begin
            v_first_reg <= wdata;
        end
        if (wr_second)
        begin
            v_second_reg <= wdata;
        end
    end

    assign own_first  = v_first_reg;
    assign own_second = v_second_reg;

    // Form the edge normal; the last vertex closes back to vertex 0
    assign axis_first  = make_axis(v_first_reg,
                                   wrap_first ? head_first : next_first, act_first);
    assign axis_second = make_axis(v_second_reg,
                                   wrap_second ? head_second : next_second, act_second);

    // Stage A: project this cell's vertices onto the passing axis
    assign prod_fx_next = PROD_W'(tok_in.ax) * PROD_W'(v_first_reg.x);
    assign prod_fy_next = PROD_W'(tok_in.ay) * PROD_W'(v_first_reg.y);
    assign prod_sx_next = PROD_W'(tok_in.ax) * PROD_W'(v_second_reg.x);
    assign prod_sy_next = PROD_W'(tok_in.ay) * PROD_W'(v_second_reg.y);

    always_ff @(posedge clk)
    begin
        prod_fx_reg <= prod_fx_next;
        prod_fy_reg <= prod_fy_next;
        prod_sx_reg <= prod_sx_next;
        prod_sy_reg <= prod_sy_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_a_reg <= '0;
            tok_b_reg <= '0;
        end
        else
        begin
            tok_a_reg <= tok_in;
            tok_b_reg <= tok_b_next;
        end
    end

    // Stage B: sum the products and widen the running intervals
    assign dot_first  = DOT_W'(prod_fx_reg) + DOT_W'(prod_fy_reg);
    assign dot_second = DOT_W'(prod_sx_reg) + DOT_W'(prod_sy_reg);

    always_comb
    begin
        tok_b_next = tok_a_reg;
        if (tok_a_reg.valid && act_first)
        begin
            if (!tok_a_reg.have1)
            begin
                tok_b_next.have1 = 1'b1;
                tok_b_next.min1  = dot_first;
                tok_b_next.max1  = dot_first;
            end
            else
            begin
                if (dot_first < tok_a_reg.min1)
                begin
                    tok_b_next.min1 = dot_first;
                end
                if (dot_first > tok_a_reg.max1)
                begin
                    tok_b_next.max1 = dot_first;
                end
            end
        end
        if (tok_a_reg.valid && act_second)
        begin
            if (!tok_a_reg.have2)
            begin
                tok_b_next.have2 = 1'b1;
                tok_b_next.min2  = dot_second;
                tok_b_next.max2  = dot_second;
            end
            else
            begin
                if (dot_second < tok_a_reg.min2)
                begin
                    tok_b_next.min2 = dot_second;
                end
                if (dot_second > tok_a_reg.max2)
                begin
                    tok_b_next.max2 = dot_second;
                end
            end
        end
    end

    assign tok_out = tok_b_reg;

endmodule

// ----- hw/rtl/cpsat_axis_chain.sv -----
`timescale 1ns / 1ps

module cpsat_axis_chain
    import cpsat_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  logic                   shift,
    input  axis_t [NUM_AXES-1:0]   axes_in,
    output axis_t                  head
);

    axis_t slot_reg  [NUM_AXES];
    axis_t slot_next [NUM_AXES];

    // Load every edge normal at once, then drain them toward the head
    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            slot_next[i] = slot_reg[i];
        end
        if (load)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                slot_next[i]      = axes_in[i];
                slot_next[i].last = 1'b0;
            end
            slot_next[NUM_AXES-1].last = 1'b1;
        end
        else if (shift)
        begin
            for (int i = 0; i < NUM_AXES - 1; i++)
            begin
                slot_next[i] = slot_reg[i+1];
            end
            slot_next[NUM_AXES-1] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                slot_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                slot_reg[i] <= slot_next[i];
            end
        end
    end

    assign head = slot_reg[0];

endmodule

// ----- hw/rtl/cpsat_judge.sv -----
`timescale 1ns / 1ps
`include "convex_polygon_sat_collision_core_defines.svh"

module cpsat_judge
    import cpsat_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  token_t     tok,
    input  logic       err_valid,
    input  logic [1:0] err_status,
    output logic       done,
    output result_t    result
);

    logic    sep_reg, sep_next;
    logic    done_reg, done_next;
    result_t result_reg, result_next;
    logic    gap;
    logic    hit;

    // Test the gap between the two projection intervals
    assign gap = (tok.min1 < tok.min2) ? (tok.min2 > tok.max1) : (tok.min1 > tok.max2);
    assign hit = tok.valid && gap;

    // Accumulate separation over all axes; report on the closing axis or on an error word
    always_comb
    begin
        sep_next    = sep_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        if (tok.last)
        begin
            sep_next                  = 1'b0;
            done_next                 = 1'b1;
            result_next.intersect_res = !(sep_reg || hit);
            result_next.status        = STATUS_OK;
        end
        else
        begin
            if (hit)
            begin
                sep_next = 1'b1;
            end
            if (err_valid)
            begin
                done_next                 = 1'b1;
                result_next.intersect_res = 1'b0;
                result_next.status        = err_status;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            sep_reg  <= sep_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    `CPSAT_CHECK(a_tok_has_both, tok.valid, tok.have1 && tok.have2, "axis without both intervals")
    `CPSAT_CHECK(a_interval_order, tok.have1, tok.min1 <= tok.max1, "first interval inverted")
    `CPSAT_CHECK(a_error_no_hit, done && result.status != STATUS_OK, !result.intersect_res, "error word flags hit")

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import cpsat_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int WORD_TARGET  = 500;
    localparam int DRAIN_CYCLES = 100;

    // Track stored vertices and predict the verdict of each pair
    class collision_tracker;
        longint      vx[2][MAX_VERTICES];
        longint      vy[2][MAX_VERTICES];
        int unsigned held[2];
        bit          dropped;
        result_t     verdicts[$];
        int          errors;

        function new();
            held[0] = 0;
            held[1] = 0;
            dropped = 1'b0;
            errors  = 0;
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("[%0t] mismatch: %s", $time, what);
        endtask

        // Project every vertex of one polygon onto the axis, keep the extremes
        function void span(int p, longint ax, longint ay, output longint lo, output longint hi);
            longint d;
            lo = ax * vx[p][0] + ay * vy[p][0];
            hi = lo;
            for (int i = 1; i < held[p]; i++) begin
                d = ax * vx[p][i] + ay * vy[p][i];
                if (d < lo)
                    lo = d;
                else if (d > hi)
                    hi = d;
            end
        endfunction

        // Walk every edge normal of both polygons, look for a gap
        function bit no_separating_axis();
            int unsigned j;
            longint      ex;
            longint      ey;
            longint      lo1;
            longint      hi1;
            longint      lo2;
            longint      hi2;
            bit          gap;
            for (int p = 0; p < 2; p++) begin
                for (int unsigned i = 0; i < held[p]; i++) begin
                    j  = (i + 1 < held[p]) ? i + 1 : 0;
                    ex = vx[p][j] - vx[p][i];
                    ey = vy[p][j] - vy[p][i];
                    span(0, -ey, ex, lo1, hi1);
                    span(1, -ey, ex, lo2, hi2);
                    gap = (lo1 < lo2) ? (lo2 > hi1) : (lo1 > hi2);
                    if (gap)
                        return 1'b0;
                end
            end
            return 1'b1;
        endfunction

        // Store one accepted word, queue a verdict when it closes the pair
        function void note_word(item_t w);
            int      p;
            result_t r;
            p = (w.func == POLY_SECOND) ? 1 : 0;
            if (held[p] < MAX_VERTICES) begin
                vx[p][held[p]] = longint'(w.vertex_x);
                vy[p][held[p]] = longint'(w.vertex_y);
                held[p]++;
            end else begin
                dropped = 1'b1;
            end
            if (!w.pair_done)
                return;
            r.intersect_res = 1'b0;
            if (dropped) begin
                r.status = STATUS_OVERFLOW;
            end else if (held[0] == 0 || held[1] == 0) begin
                r.status = STATUS_EMPTY;
            end else begin
                r.status        = STATUS_OK;
                r.intersect_res = no_separating_axis();
            end
            verdicts.push_back(r);
            held[0] = 0;
            held[1] = 0;
            dropped = 1'b0;
        endfunction

        // Compare one result word with the oldest queued verdict
        task check_result(result_t got);
            result_t want;
            if (verdicts.size() == 0) begin
                report_mismatch($sformatf("unexpected word intersect=%b status=%0d",
                                          got.intersect_res, got.status));
                return;
            end
            want = verdicts.pop_front();
            if (got.intersect_res !== want.intersect_res)
                report_mismatch($sformatf("intersect_res got %b want %b",
                                          got.intersect_res, want.intersect_res));
            if (got.status !== want.status)
                report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
        endtask
    endclass

    logic    clk   = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    item_t   item  = '0;
    logic    busy;
    logic    done;
    result_t result;

    collision_tracker sb = new();
    int               words_sent = 0;
    int               cycles = 0;
    bit               no_gaps = 1'b0;

    convex_polygon_sat_collision_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Check results first, then note the word accepted on this edge
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (done)
                sb.check_result(result);
            if (start && !busy)
                sb.note_word(item);
        end
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    function automatic int clamp16(int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic int any_coord();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    function automatic int pick_count();
        if ($urandom_range(0, 4) == 0)
            return $urandom_range(7, MAX_VERTICES);
        return $urandom_range(1, 6);
    endfunction

    // Offer one word, hold it until the block takes it
    task automatic send_word(logic poly, int x, int y, logic last);
        item_t w;
        int    gap;
        w.func      = poly;
        w.vertex_x  = x[COORD_WIDTH-1:0];
        w.vertex_y  = y[COORD_WIDTH-1:0];
        w.pair_done = last;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item  <= w;
        do
            @(posedge clk);
        while (busy);
        words_sent++;
    endtask

    // Interleave the two polygons at random, flag the final word
    task automatic send_pair(input int ax[$], input int ay[$], input int bx[$], input int by[$]);
        int i1;
        int i2;
        int total;
        int pick;
        i1    = 0;
        i2    = 0;
        total = ax.size() + bx.size();
        for (int k = 0; k < total; k++) begin
            if (i1 == ax.size())
                pick = 1;
            else if (i2 == bx.size())
                pick = 0;
            else
                pick = $urandom_range(0, 1);
            if (pick == 0) begin
                send_word(POLY_FIRST, ax[i1], ay[i1], k == total - 1);
                i1++;
            end else begin
                send_word(POLY_SECOND, bx[i2], by[i2], k == total - 1);
                i2++;
            end
        end
    endtask

    // Place n vertices on a circle in rising angle order (convex)
    task automatic make_ring(int n, int cx, int cy, int r, ref int xs[$], ref int ys[$]);
        real step;
        real base;
        real ang;
        xs = {};
        ys = {};
        if (n == 0)
            return;
        step = 2.0 * 3.14159265 / n;
        base = $urandom_range(0, 628) / 100.0;
        for (int k = 0; k < n; k++) begin
            ang = base + step * k + step * 0.4 * ($urandom_range(0, 100) / 100.0);
            xs.push_back(clamp16(cx + $rtoi(r * $cos(ang))));
            ys.push_back(clamp16(cy + $rtoi(r * $sin(ang))));
        end
    endtask

    task automatic make_noise(int n, ref int xs[$], ref int ys[$]);
        xs = {};
        ys = {};
        for (int k = 0; k < n; k++) begin
            xs.push_back(any_coord());
            ys.push_back(any_coord());
        end
    endtask

    initial
    begin
        int ax[$];
        int ay[$];
        int bx[$];
        int by[$];
        int kind;
        int r1;
        int r2;
        int cx;
        int cy;
        int reach;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Second polygon empty
        ax = {0};
        ay = {0};
        bx = {};
        by = {};
        send_pair(ax, ay, bx, by);
        // Single-vertex polygons at opposite extremes: only zero-length axes, no gap
        ax = {-32768};
        ay = {32767};
        bx = {32767};
        by = {-32768};
        send_pair(ax, ay, bx, by);
        // Full-range triangle around a small one
        ax = {-32768, 32767, 32767};
        ay = {-32768, -32768, 32767};
        bx = {100, 200, 200};
        by = {-100, -100, 0};
        send_pair(ax, ay, bx, by);
        // Squares sharing an edge: touching, with a repeated vertex
        ax = {0, 0, 16, 16, 0};
        ay = {0, 0, 0, 16, 16};
        bx = {16, 32, 32, 16};
        by = {0, 0, 16, 16};
        send_pair(ax, ay, bx, by);
        // Squares one step apart
        ax = {0, 16, 16, 0};
        ay = {0, 0, 16, 16};
        bx = {17, 33, 33, 17};
        by = {0, 0, 16, 16};
        send_pair(ax, ay, bx, by);

        // Random pairs, mostly nearby convex shapes
        while (words_sent < WORD_TARGET) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            kind    = $urandom_range(0, 19);
            if (kind < 14) begin
                r1    = $urandom_range(16, 3000);
                r2    = $urandom_range(16, 3000);
                cx    = int'($urandom_range(0, 40000)) - 20000;
                cy    = int'($urandom_range(0, 40000)) - 20000;
                reach = r1 + r2;
                make_ring(pick_count(), cx, cy, r1, ax, ay);
                make_ring(pick_count(), cx + int'($urandom_range(0, 2 * reach)) - reach,
                          cy + int'($urandom_range(0, 2 * reach)) - reach, r2, bx, by);
            end else if (kind < 17) begin
                make_noise($urandom_range(1, 5), ax, ay);
                make_noise($urandom_range(1, 5), bx, by);
            end else if (kind < 19) begin
                make_ring($urandom_range(MAX_VERTICES + 1, MAX_VERTICES + 4),
                          0, 0, $urandom_range(16, 2000), ax, ay);
                make_noise($urandom_range(0, 4), bx, by);
            end else begin
                make_noise($urandom_range(1, 4), ax, ay);
                bx = {};
                by = {};
            end
            if ($urandom_range(0, 1) == 1)
                send_pair(ax, ay, bx, by);
            else
                send_pair(bx, by, ax, ay);
        end

        // Drain outstanding verdicts
        start <= 1'b0;
        while (sb.verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

// ----- convex_polygon_sat_collision_core.f -----
+incdir+hw/rtl
hw/rtl/cpsat_pkg.sv
hw/rtl/cpsat_cell.sv
hw/rtl/cpsat_axis_chain.sv
hw/rtl/cpsat_judge.sv
hw/rtl/convex_polygon_sat_collision_core.sv
tb/sv/tb.sv
